@@ design/sphm_pkg.sv @@
package sphm_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int NORMAL_DEPTH = 4096;
    localparam int VTX_AW       = $clog2(VERTEX_DEPTH);
    localparam int NRM_AW       = $clog2(NORMAL_DEPTH);
    localparam int FRAC_BITS    = 16;
    localparam int SLOT_W       = 12;

    // input item kinds (tuser)
    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_FETCH    = 2'd2;

    // result kinds
    localparam logic RES_VERTEX = 1'b0;
    localparam logic RES_NORMAL = 1'b1;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_CENTER_Z = 3'd2;
    localparam logic [2:0] REG_RADIUS   = 3'd3;
    localparam logic [2:0] REG_WEIGHT   = 3'd4;

    localparam logic [30:0] RADIUS_RESET = 31'd65536;
    localparam logic signed [31:0] UNIT_ONE = 32'sd1 <<< FRAC_BITS;

endpackage

@@ design/sphere_morph_vertex_normals.sv @@
// Channel   | Dir | Handshake             | Beat contents
// ----------+-----+-----------------------+--------------------------------------------
// s_axis    | in  | tvalid/tready         | tuser: kind; tdata: position, slots
// m_axis    | out | tvalid/tready         | tuser: result_kind; tdata: slot, x, y, z
// apb       | in  | psel/penable/pready   | center_x/y/z, sphere_radius, interp_weight
//
// One item at a time: a new item is accepted only once the last one is done. The work is
// set by the one-bit-a-cycle scaling shifts, a 32-step square root and three 32-step
// divisions on one shared restoring divider; a vertex at the center, a zero cross product
// and an empty fetch entry skip the root and the divisions.
// After reset a clearing pass zeroes all 4096 entries of the normal memory; s_axis_tready stays
// low meanwhile, configuration writes are taken.
// The output register holds a result until the sink takes it; a new beat is accepted
// while it waits, and the next result holds in S_EMIT until the register frees.
module sphere_morph_vertex_normals
    import sphm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, vertex_slot, corner_vertex_a/b/c, normal_slot_a/b/c, pad
    input  logic [183:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_slot, out_x, out_y, out_z, pad
    output logic [111:0] m_axis_tdata,
    // result_kind
    output logic [0:0]   m_axis_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_TRD   = 5'd2;
    localparam logic [4:0] S_EDGE  = 5'd3;
    localparam logic [4:0] S_CROSS = 5'd4;
    localparam logic [4:0] S_CRMAG = 5'd5;
    localparam logic [4:0] S_FRD   = 5'd6;
    localparam logic [4:0] S_FWR   = 5'd7;
    localparam logic [4:0] S_SCALE = 5'd8;
    localparam logic [4:0] S_SQ    = 5'd9;
    localparam logic [4:0] S_SQRT  = 5'd10;
    localparam logic [4:0] S_DMUL  = 5'd11;
    localparam logic [4:0] S_DPRE  = 5'd12;
    localparam logic [4:0] S_DIV   = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_BMUL  = 5'd15;
    localparam logic [4:0] S_BADD  = 5'd16;
    localparam logic [4:0] S_ARD   = 5'd17;
    localparam logic [4:0] S_AWR   = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    // ------------------------------------------------------------------ registers
    logic [4:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [NRM_AW-1:0] clr_cnt_reg;
    logic        out_valid_reg;

    logic signed [31:0] center_reg [3];
    logic [30:0] radius_reg;
    logic [16:0] weight_reg;

    logic [1:0]  kind_reg;
    logic        vtx_mode_reg;
    logic signed [31:0] pos_reg [3];
    logic [SLOT_W-1:0] vslot_reg;
    logic [SLOT_W-1:0] cslot_reg [3];
    logic [SLOT_W-1:0] nslot_reg [3];

    logic signed [31:0] p_reg [3][3];
    logic signed [31:0] e1_reg [3];
    logic signed [31:0] e2_reg [3];
    logic signed [68:0] prod_reg;
    logic signed [64:0] cr_reg [3];
    logic        neg_reg [3];
    logic [63:0] mag_reg [3];
    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] b_reg;
    logic [30:0] len_reg;
    logic [30:0] rem_reg;
    logic [31:0] numlo_reg;
    logic [31:0] qacc_reg;
    logic [31:0] q_reg [3];
    logic signed [31:0] res_reg [3];

    logic [0:0]  out_kind_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [31:0] out_x_reg, out_y_reg, out_z_reg;

    logic [95:0]  vtx_mem [VERTEX_DEPTH];
    logic [95:0]  vtx_rdata_reg;
    logic [191:0] nrm_mem [NORMAL_DEPTH];
    logic [191:0] nrm_rdata_reg;

    // ------------------------------------------------------------------ handshakes
    logic in_acc, out_free, cfg_wr;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign pready        = 1'b1;
    assign cfg_wr        = psel && penable && pwrite && pready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {4'd0, out_z_reg, out_y_reg, out_x_reg, out_slot_reg};

    // ------------------------------------------------------------------ input fields
    logic signed [31:0] in_pos [3];
    logic signed [32:0] in_d [3];

    always_comb
    begin
        in_pos[0] = s_axis_tdata[31:0];
        in_pos[1] = s_axis_tdata[63:32];
        in_pos[2] = s_axis_tdata[95:64];
        for (int i = 0; i < 3; i++)
        begin
            in_d[i] = 33'(in_pos[i]) - 33'(center_reg[i]);
        end
    end

    // ------------------------------------------------------------------ register read
    always_comb
    begin
        unique case (paddr[4:2])
            REG_CENTER_X: prdata = center_reg[0];
            REG_CENTER_Y: prdata = center_reg[1];
            REG_CENTER_Z: prdata = center_reg[2];
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            REG_WEIGHT:   prdata = {15'd0, weight_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------ triangle edges
    function automatic logic signed [31:0] halve_tz(input logic signed [32:0] x);
        logic [32:0] m;
        m = x[32] ? 33'(-x) : 33'(x);
        m = m >> 1;
        return x[32] ? 32'(-$signed(m)) : 32'($signed(m));
    endfunction

    logic signed [32:0] ed1 [3];
    logic signed [32:0] ed2 [3];
    logic               edge_big;

    always_comb
    begin
        edge_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ed1[i] = 33'(p_reg[1][i]) - 33'(p_reg[0][i]);
            ed2[i] = 33'(p_reg[2][i]) - 33'(p_reg[0][i]);
            if (ed1[i] >= 33'sd2147483648 || ed1[i] <= -33'sd2147483648 ||
                ed2[i] >= 33'sd2147483648 || ed2[i] <= -33'sd2147483648)
            begin
                edge_big = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------ largest magnitude
    logic [63:0] mx;

    always_comb
    begin
        mx = mag_reg[0];
        if (mag_reg[1] > mx) mx = mag_reg[1];
        if (mag_reg[2] > mx) mx = mag_reg[2];
    end

    // ------------------------------------------------------------------ blend terms
    logic signed [33:0] q_signed;
    logic signed [34:0] end_val;
    logic signed [35:0] diff_val;

    always_comb
    begin
        q_signed = neg_reg[comp_reg] ? -$signed({2'b00, q_reg[comp_reg]})
                                     :  $signed({2'b00, q_reg[comp_reg]});
        end_val  = 35'(center_reg[comp_reg]) + 35'(q_signed);
        diff_val = 36'(end_val) - 36'(pos_reg[comp_reg]);
    end

    // ------------------------------------------------------------------ shared multiplier
    logic signed [35:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] mul_p;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_CROSS:
            begin
                case (cnt_reg[2:0])
                    3'd0:    begin mul_a = 36'(e1_reg[1]); mul_b = 33'(e2_reg[2]); end
                    3'd1:    begin mul_a = 36'(e1_reg[2]); mul_b = 33'(e2_reg[1]); end
                    3'd2:    begin mul_a = 36'(e1_reg[2]); mul_b = 33'(e2_reg[0]); end
                    3'd3:    begin mul_a = 36'(e1_reg[0]); mul_b = 33'(e2_reg[2]); end
                    3'd4:    begin mul_a = 36'(e1_reg[0]); mul_b = 33'(e2_reg[1]); end
                    3'd5:    begin mul_a = 36'(e1_reg[1]); mul_b = 33'(e2_reg[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_SQ:
            begin
                if (cnt_reg[1:0] != 2'd3)
                begin
                    mul_a = $signed({6'd0, mag_reg[cnt_reg[1:0]][29:0]});
                    mul_b = $signed({3'd0, mag_reg[cnt_reg[1:0]][29:0]});
                end
            end
            S_DMUL:
            begin
                mul_a = $signed({6'd0, mag_reg[comp_reg][29:0]});
                mul_b = $signed({2'd0, radius_reg});
            end
            S_BMUL:
            begin
                mul_a = diff_val;
                mul_b = $signed({16'd0, weight_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = 69'(mul_a) * 69'(mul_b);
    end

    // ------------------------------------------------------------------ sqrt and divide steps
    logic [63:0] rb_sum, v_next, r_next;
    logic [31:0] div_t;
    logic        div_ge;
    logic [30:0] rem_next;
    logic [31:0] qacc_next;
    logic [61:0] num_r;

    always_comb
    begin
        rb_sum = r_reg + b_reg;
        if (v_reg >= rb_sum)
        begin
            v_next = v_reg - rb_sum;
            r_next = (r_reg >> 1) + b_reg;
        end
        else
        begin
            v_next = v_reg;
            r_next = r_reg >> 1;
        end

        div_t     = {rem_reg, numlo_reg[31]};
        div_ge    = (div_t >= {1'b0, len_reg});
        rem_next  = div_ge ? 31'(div_t - {1'b0, len_reg}) : div_t[30:0];
        qacc_next = {qacc_reg[30:0], div_ge};

        num_r = (vtx_mode_reg ? prod_reg[61:0]
                              : 62'(mag_reg[comp_reg][29:0]) << FRAC_BITS)
              + 62'(len_reg >> 1);
    end

    // ------------------------------------------------------------------ blend result
    logic signed [68:0] blend_t;
    logic signed [55:0] blend_sum;
    logic signed [31:0] blend_sat;

    always_comb
    begin
        blend_t   = (prod_reg + 69'sd32768) >>> 16;
        blend_sum = 56'(pos_reg[comp_reg]) + 56'(blend_t);
        if (blend_sum > 56'sd2147483647)
            blend_sat = 32'sh7FFFFFFF;
        else if (blend_sum < -56'sd2147483648)
            blend_sat = 32'sh80000000;
        else
            blend_sat = blend_sum[31:0];
    end

    // ------------------------------------------------------------------ memory ports
    logic [VTX_AW-1:0] vtx_raddr;
    logic              vtx_we;
    logic [NRM_AW-1:0] nrm_raddr, nrm_waddr;
    logic              nrm_we;
    logic [191:0]      nrm_wdata;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    vtx_raddr = VTX_AW'(cslot_reg[0]);
            2'd1:    vtx_raddr = VTX_AW'(cslot_reg[1]);
            default: vtx_raddr = VTX_AW'(cslot_reg[2]);
        endcase
        vtx_we = (state_reg == S_EMIT) && out_free && (kind_reg == KIND_VERTEX);

        nrm_raddr = (state_reg == S_FRD) ? NRM_AW'(nslot_reg[0])
                                         : NRM_AW'(nslot_reg[comp_reg]);
        nrm_we    = 1'b0;
        nrm_waddr = NRM_AW'(nslot_reg[comp_reg]);
        nrm_wdata = '0;
        unique case (state_reg)
            S_CLR:
            begin
                nrm_we    = 1'b1;
                nrm_waddr = clr_cnt_reg;
            end
            S_FWR:
            begin
                // drop the entry once fetched
                nrm_we    = 1'b1;
                nrm_waddr = NRM_AW'(nslot_reg[0]);
            end
            S_AWR:
            begin
                nrm_we = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    nrm_wdata[64*i +: 64] = nrm_rdata_reg[64*i +: 64] + 64'(res_reg[i]);
                end
            end
            default:
            begin
                nrm_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (vtx_we)
        begin
            vtx_mem[VTX_AW'(vslot_reg)] <= {res_reg[2], res_reg[1], res_reg[0]};
        end
        vtx_rdata_reg <= vtx_mem[vtx_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (nrm_we)
        begin
            nrm_mem[nrm_waddr] <= nrm_wdata;
        end
        nrm_rdata_reg <= nrm_mem[nrm_raddr];
    end

    // ------------------------------------------------------------------ control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cnt_reg       <= '0;
            comp_reg      <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            center_reg[0] <= '0;
            center_reg[1] <= '0;
            center_reg[2] <= '0;
            radius_reg    <= RADIUS_RESET;
            weight_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[4:2])
                    REG_CENTER_X: center_reg[0] <= pwdata;
                    REG_CENTER_Y: center_reg[1] <= pwdata;
                    REG_CENTER_Z: center_reg[2] <= pwdata;
                    REG_RADIUS:   radius_reg    <= pwdata[30:0];
                    REG_WEIGHT:   weight_reg    <= pwdata[16:0];
                    default:      ;
                endcase
            end

            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == NRM_AW'(NORMAL_DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    cnt_reg  <= '0;
                    comp_reg <= '0;
                    if (in_acc)
                    begin
                        case (s_axis_tuser)
                            KIND_VERTEX:   state_reg <= S_SCALE;
                            KIND_TRIANGLE: state_reg <= S_TRD;
                            KIND_FETCH:    state_reg <= S_FRD;
                            default:       state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_TRD:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd3)
                        state_reg <= S_EDGE;
                end
                S_EDGE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_CROSS;
                end
                S_CROSS:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd6)
                        state_reg <= S_CRMAG;
                end
                S_CRMAG: state_reg <= S_SCALE;
                S_FRD:   state_reg <= S_FWR;
                S_FWR:   state_reg <= S_SCALE;
                S_SCALE:
                begin
                    cnt_reg  <= '0;
                    comp_reg <= '0;
                    if (mx == 64'd0)
                        state_reg <= (kind_reg == KIND_TRIANGLE) ? S_ARD : S_EMIT;
                    else if (mx[63:30] == '0 && mx[29])
                        state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (cnt_reg == 5'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                        state_reg <= S_DMUL;
                end
                S_DMUL: state_reg <= S_DPRE;
                S_DPRE:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31)
                    begin
                        if (comp_reg == 2'd2)
                        begin
                            comp_reg  <= '0;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 1'b1;
                            state_reg <= S_DMUL;
                        end
                    end
                end
                S_FIN:
                begin
                    if (vtx_mode_reg)
                        state_reg <= S_BMUL;
                    else if (kind_reg == KIND_TRIANGLE)
                        state_reg <= S_ARD;
                    else
                        state_reg <= S_EMIT;
                end
                S_BMUL: state_reg <= S_BADD;
                S_BADD:
                begin
                    if (comp_reg == 2'd2)
                        state_reg <= S_EMIT;
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= S_BMUL;
                    end
                end
                S_ARD: state_reg <= S_AWR;
                S_AWR:
                begin
                    if (comp_reg == 2'd2)
                        state_reg <= S_IDLE;
                    else
                    begin
                        comp_reg  <= comp_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------ datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_reg     <= s_axis_tuser;
                    vtx_mode_reg <= (s_axis_tuser == KIND_VERTEX);
                    vslot_reg    <= s_axis_tdata[107:96];
                    cslot_reg[0] <= s_axis_tdata[119:108];
                    cslot_reg[1] <= s_axis_tdata[131:120];
                    cslot_reg[2] <= s_axis_tdata[143:132];
                    nslot_reg[0] <= s_axis_tdata[155:144];
                    nslot_reg[1] <= s_axis_tdata[167:156];
                    nslot_reg[2] <= s_axis_tdata[179:168];
                    for (int i = 0; i < 3; i++)
                    begin
                        pos_reg[i] <= in_pos[i];
                        neg_reg[i] <= in_d[i][32];
                        mag_reg[i] <= in_d[i][32] ? 64'(-in_d[i]) : 64'(in_d[i]);
                    end
                end
            end
            S_TRD:
            begin
                if (cnt_reg[1:0] != 2'd0)
                begin
                    p_reg[cnt_reg[1:0] - 2'd1][0] <= vtx_rdata_reg[31:0];
                    p_reg[cnt_reg[1:0] - 2'd1][1] <= vtx_rdata_reg[63:32];
                    p_reg[cnt_reg[1:0] - 2'd1][2] <= vtx_rdata_reg[95:64];
                end
            end
            S_EDGE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    e1_reg[i] <= edge_big ? halve_tz(ed1[i]) : ed1[i][31:0];
                    e2_reg[i] <= edge_big ? halve_tz(ed2[i]) : ed2[i][31:0];
                end
            end
            S_CROSS:
            begin
                prod_reg <= mul_p;
                // odd steps open a component, even steps subtract the second term
                if (cnt_reg != 5'd0)
                begin
                    if (cnt_reg[0])
                        cr_reg[2'((cnt_reg - 5'd1) >> 1)] <= 65'(prod_reg);
                    else
                        cr_reg[2'((cnt_reg - 5'd1) >> 1)] <=
                            cr_reg[2'((cnt_reg - 5'd1) >> 1)] - 65'(prod_reg);
                end
            end
            S_CRMAG:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= cr_reg[i][64];
                    mag_reg[i] <= cr_reg[i][64] ? 64'(-cr_reg[i]) : 64'(cr_reg[i]);
                end
            end
            S_FWR:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= nrm_rdata_reg[64*i + 63];
                    mag_reg[i] <= nrm_rdata_reg[64*i + 63] ? -nrm_rdata_reg[64*i +: 64]
                                                           :  nrm_rdata_reg[64*i +: 64];
                end
            end
            S_SCALE:
            begin
                if (mx == 64'd0)
                begin
                    // zero vector: vertex stays put, normal falls back to +y
                    for (int i = 0; i < 3; i++)
                    begin
                        if (vtx_mode_reg)
                            res_reg[i] <= pos_reg[i];
                        else
                            res_reg[i] <= (i == 1) ? UNIT_ONE : 32'sd0;
                    end
                end
                else if (mx[63:30] != '0)
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else if (!mx[29])
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
            end
            S_SQ:
            begin
                prod_reg <= mul_p;
                if (cnt_reg == 5'd1)
                    v_reg <= prod_reg[63:0];
                else if (cnt_reg != 5'd0)
                    v_reg <= v_reg + prod_reg[63:0];
                r_reg <= '0;
                b_reg <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                v_reg <= v_next;
                r_reg <= r_next;
                b_reg <= b_reg >> 2;
                if (cnt_reg == 5'd31)
                    len_reg <= r_next[30:0];
            end
            S_DMUL:
            begin
                prod_reg <= mul_p;
            end
            S_DPRE:
            begin
                rem_reg   <= {1'b0, num_r[61:32]};
                numlo_reg <= num_r[31:0];
                qacc_reg  <= '0;
            end
            S_DIV:
            begin
                rem_reg   <= rem_next;
                numlo_reg <= numlo_reg << 1;
                qacc_reg  <= qacc_next;
                if (cnt_reg == 5'd31)
                    q_reg[comp_reg] <= qacc_next;
            end
            S_FIN:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    res_reg[i] <= neg_reg[i] ? -$signed(q_reg[i]) : $signed(q_reg[i]);
                end
            end
            S_BMUL:
            begin
                prod_reg <= mul_p;
            end
            S_BADD:
            begin
                res_reg[comp_reg] <= blend_sat;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_kind_reg <= (kind_reg == KIND_VERTEX) ? RES_VERTEX : RES_NORMAL;
                    out_slot_reg <= (kind_reg == KIND_VERTEX) ? vslot_reg : nslot_reg[0];
                    out_x_reg    <= res_reg[0];
                    out_y_reg    <= res_reg[1];
                    out_z_reg    <= res_reg[2];
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------ checks
    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_scaled_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQ |-> (mx[63:30] == '0 && mx[29]))
        else $error("magnitudes left scaling out of range");

    a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SQRT |-> $onehot(b_reg))
        else $error("square root bit lost");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < len_reg)
        else $error("divider remainder not below length");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

// Block-level bench for sphere_morph_vertex_normals.
// Vertex, triangle, fetch and idle-kind beats go in on s_axis, with random gaps between them.
// The local morph/normal predictor keeps its own vertex store and normal accumulators.
// It queues one expected beat per vertex or fetch.
// The m_axis monitor checks each result beat against the oldest queued one.
module testbench;
    import sphm_pkg::*;

    localparam logic [1:0] KIND_IDLE  = 2'd3;   // no result, no state change
    localparam int         CLK_HALF   = 10;
    localparam int         SETTLE     = 400;    // longer than the slowest item
    localparam longint     CYCLE_CAP  = 1000000;
    localparam int         MAX_SHOWN  = 10;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] px, py, pz;
        logic [11:0]        vslot, ca, cb, cc, na, nb, nc;
    } item_t;

    typedef struct {
        logic        rkind;
        logic [11:0] slot;
        logic [31:0] x, y, z;
    } beat_t;

    typedef struct packed {
        logic [31:0] x, y, z;
    } vec_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // pos_x, pos_y, pos_z, vertex_slot, corner_vertex_a/b/c, normal_slot_a/b/c, pad
    logic [183:0] s_axis_tdata = '0;
    // kind
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // result_slot, out_x, out_y, out_z, pad
    logic [111:0] m_axis_tdata;
    // result_kind
    logic [0:0]   m_axis_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    sphere_morph_vertex_normals u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #(CLK_HALF) clk = ~clk;

    // Predictor state: configuration, moved vertices, normal sums.
    longint          ctr [3];
    logic [63:0]     radius;
    logic [63:0]     weight;
    logic [31:0]     vtx_store [VERTEX_DEPTH][3];
    logic [63:0]     nrm_sum   [NORMAL_DEPTH][3];
    bit              vtx_written [VERTEX_DEPTH];
    int unsigned     written_list [$];

    beat_t           expected_beats [$];
    int unsigned     mismatches = 0;
    int unsigned     beats_checked = 0;
    int unsigned     n_vertex = 0, n_triangle = 0, n_fetch = 0, n_idle = 0;
    longint          cycles = 0;

    // Receiver control: a requested hold-off wins over the random stalls.
    int unsigned     hold_cycles = 0;
    int unsigned     sink_stall = 0;
    bit              calm = 0;

    //------------------------------------------------------------------
    // Arithmetic of the predictor
    //------------------------------------------------------------------
    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Normalize magnitudes so the largest lies in [2^29, 2^30); return length.
    function automatic logic [63:0] scaled_len(inout logic [63:0] m0, m1, m2);
        logic [63:0] mx;
        mx = m0;
        if (m1 > mx) mx = m1;
        if (m2 > mx) mx = m2;
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            m0 = m0 >> 1; m1 = m1 >> 1; m2 = m2 >> 1; mx = mx >> 1;
        end
        while (mx < (64'd1 << 29)) begin
            m0 = m0 << 1; m1 = m1 << 1; m2 = m2 << 1; mx = mx << 1;
        end
        return int_sqrt(m0 * m0 + m1 * m1 + m2 * m2);
    endfunction

    function automatic longint round_div(bit neg, logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        q = (num + den / 2) / den;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // Zero vector maps to (0,1,0).
    function automatic vec_t unit_vec(longint v0, longint v1, longint v2);
        logic [63:0] m0, m1, m2, len;
        vec_t u;
        m0 = mag(v0); m1 = mag(v1); m2 = mag(v2);
        len = scaled_len(m0, m1, m2);
        if (len == 0) begin
            u.x = 0; u.y = 32'(UNIT_ONE); u.z = 0;
            return u;
        end
        u.x = 32'(round_div(v0 < 0, m0 << FRAC_BITS, len));
        u.y = 32'(round_div(v1 < 0, m1 << FRAC_BITS, len));
        u.z = 32'(round_div(v2 < 0, m2 << FRAC_BITS, len));
        return u;
    endfunction

    function automatic longint halve_tz(longint v);
        return v < 0 ? -((-v) >>> 1) : (v >>> 1);
    endfunction

    // Advance the predictor by one accepted beat; queue its result if any.
    task automatic predict_beat(item_t it);
        longint      pos [3], d [3], p [3][3], e1 [3], e2 [3], cr [3];
        logic [63:0] m [3], len, mx;
        longint      fin, r;
        logic [11:0] slots [3];
        vec_t        u;
        beat_t       b;
        case (it.kind)
            KIND_VERTEX: begin
                n_vertex++;
                pos[0] = it.px; pos[1] = it.py; pos[2] = it.pz;
                for (int i = 0; i < 3; i++) begin
                    d[i] = pos[i] - ctr[i];
                    m[i] = mag(d[i]);
                end
                len = scaled_len(m[0], m[1], m[2]);
                for (int i = 0; i < 3; i++) begin
                    if (len == 0) fin = pos[i];
                    else fin = ctr[i] + round_div(d[i] < 0, m[i] * radius, len);
                    r = pos[i] + (((fin - pos[i]) * longint'(weight) + 32768) >>> 16);
                    if (r > 64'sd2147483647) r = 64'sd2147483647;
                    if (r < -64'sd2147483648) r = -64'sd2147483648;
                    vtx_store[it.vslot][i] = 32'(r);
                end
                if (!vtx_written[it.vslot]) written_list.push_back(it.vslot);
                vtx_written[it.vslot] = 1;
                b.rkind = RES_VERTEX;
                b.slot  = it.vslot;
                b.x = vtx_store[it.vslot][0];
                b.y = vtx_store[it.vslot][1];
                b.z = vtx_store[it.vslot][2];
                expected_beats.push_back(b);
            end
            KIND_TRIANGLE: begin
                n_triangle++;
                slots[0] = it.ca; slots[1] = it.cb; slots[2] = it.cc;
                for (int k = 0; k < 3; k++)
                    for (int i = 0; i < 3; i++)
                        p[k][i] = longint'(signed'(vtx_store[slots[k]][i]));
                mx = 0;
                for (int i = 0; i < 3; i++) begin
                    e1[i] = p[1][i] - p[0][i];
                    e2[i] = p[2][i] - p[0][i];
                    if (mag(e1[i]) > mx) mx = mag(e1[i]);
                    if (mag(e2[i]) > mx) mx = mag(e2[i]);
                end
                if (mx >= (64'd1 << 31))
                    for (int i = 0; i < 3; i++) begin
                        e1[i] = halve_tz(e1[i]);
                        e2[i] = halve_tz(e2[i]);
                    end
                cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
                cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
                cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
                u = unit_vec(cr[0], cr[1], cr[2]);
                slots[0] = it.na; slots[1] = it.nb; slots[2] = it.nc;
                for (int k = 0; k < 3; k++) begin
                    nrm_sum[slots[k]][0] += 64'(signed'(u.x));
                    nrm_sum[slots[k]][1] += 64'(signed'(u.y));
                    nrm_sum[slots[k]][2] += 64'(signed'(u.z));
                end
            end
            KIND_FETCH: begin
                n_fetch++;
                u = unit_vec(longint'(nrm_sum[it.na][0]), longint'(nrm_sum[it.na][1]),
                             longint'(nrm_sum[it.na][2]));
                for (int i = 0; i < 3; i++) nrm_sum[it.na][i] = 0;
                b.rkind = RES_NORMAL;
                b.slot  = it.na;
                b.x = u.x; b.y = u.y; b.z = u.z;
                expected_beats.push_back(b);
            end
            default: n_idle++;
        endcase
    endtask

    //------------------------------------------------------------------
    // Bus drivers
    //------------------------------------------------------------------
    function automatic int unsigned idle_len();
        int unsigned pick;
        if (calm) return 0;
        pick = $urandom_range(99);
        if (pick < 65) return 0;
        if (pick < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Write one register; the predictor takes it at the access edge.
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge clk);
        psel = 1; penable = 0; pwrite = 1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1;
        @(posedge clk);
        case (idx)
            REG_CENTER_X: ctr[0] = longint'(signed'(value));
            REG_CENTER_Y: ctr[1] = longint'(signed'(value));
            REG_CENTER_Z: ctr[2] = longint'(signed'(value));
            REG_RADIUS:   radius = 64'(value[30:0]);
            REG_WEIGHT:   weight = 64'(value[16:0]);
            default: ;
        endcase
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    task automatic set_config(logic [31:0] cx, cy, cz, rad, w);
        reg_write(REG_CENTER_X, cx);
        reg_write(REG_CENTER_Y, cy);
        reg_write(REG_CENTER_Z, cz);
        reg_write(REG_RADIUS, rad);
        reg_write(REG_WEIGHT, w);
    endtask

    // Offer one beat, hold until accepted, then drop valid for a random gap, if any.
    task automatic send_item(item_t it);
        int unsigned gap;
        @(negedge clk);
        s_axis_tuser  = it.kind;
        s_axis_tdata  = {4'b0, it.nc, it.nb, it.na, it.cc, it.cb, it.ca, it.vslot,
                         it.pz, it.py, it.px};
        s_axis_tvalid = 1;
        do @(posedge clk); while (!s_axis_tready);
        predict_beat(it);
        gap = idle_len();
        if (gap != 0) begin
            @(negedge clk);
            s_axis_tvalid = 0;
            s_axis_tdata  = '0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Let the block go idle: every result in, then margin for a triangle in flight.
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 0;
        while (expected_beats.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic item_t blank_item(logic [1:0] kind);
        item_t it;
        it = '{kind: kind, default: '0};
        return it;
    endfunction

    function automatic item_t vertex(logic [11:0] slot, logic [31:0] x, y, z);
        item_t it;
        it = blank_item(KIND_VERTEX);
        it.vslot = slot; it.px = x; it.py = y; it.pz = z;
        return it;
    endfunction

    function automatic item_t triangle(logic [11:0] a, b, c, na, nb, nc);
        item_t it;
        it = blank_item(KIND_TRIANGLE);
        it.ca = a; it.cb = b; it.cc = c;
        it.na = na; it.nb = nb; it.nc = nc;
        return it;
    endfunction

    function automatic item_t fetch(logic [11:0] slot);
        item_t it;
        it = blank_item(KIND_FETCH);
        it.na = slot;
        return it;
    endfunction

    // Position near the center most of the time, else anywhere.
    function automatic logic [31:0] rand_pos(int axis);
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'(ctr[axis]);
            default: return 32'(ctr[axis] + longint'(signed'($urandom)) / 1024);
        endcase
    endfunction

    function automatic logic [11:0] rand_slot();
        return $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(31));
    endfunction

    // Fill the idle-kind beat's position, vertex slot, ca and nb fields with noise too.
    function automatic item_t rand_item();
        item_t it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45 || written_list.size() < 3) begin
            it = vertex(rand_slot(), rand_pos(0), rand_pos(1), rand_pos(2));
        end
        else if (pick < 75) begin
            it = triangle(written_list[$urandom_range(written_list.size() - 1)],
                          written_list[$urandom_range(written_list.size() - 1)],
                          written_list[$urandom_range(written_list.size() - 1)],
                          rand_slot(), rand_slot(), rand_slot());
        end
        else if (pick < 95) begin
            it = fetch(rand_slot());
        end
        else begin
            it = blank_item(KIND_IDLE);
            it.px = $urandom; it.py = $urandom; it.pz = $urandom;
            it.vslot = $urandom; it.ca = $urandom; it.nb = $urandom;
        end
        return it;
    endfunction

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------
    task automatic test_directed();
        // sphere of radius 4, fully on the sphere
        set_config(32'd0, 32'd0, 32'd0, 32'd262144, 32'd65536);
        send_item(vertex(12'd0, 32'd0, 32'd0, 32'd0));               // at center
        send_item(vertex(12'd4095, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_item(vertex(12'd1, 32'd65536, 32'd0, 32'd0));
        send_item(vertex(12'd2, 32'd0, 32'd65536, 32'd0));
        send_item(triangle(12'd0, 12'd1, 12'd2, 12'd0, 12'd4095, 12'd5));
        send_item(triangle(12'd1, 12'd1, 12'd2, 12'd7, 12'd7, 12'd7)); // zero cross
        send_item(triangle(12'd4095, 12'd0, 12'd1, 12'd5, 12'd6, 12'd6));
        send_item(fetch(12'd0));
        send_item(fetch(12'd7));
        send_item(fetch(12'd4095));
        send_item(fetch(12'd100));                                    // never touched
        send_item(blank_item(KIND_IDLE));
        send_item(fetch(12'd5));
        send_item(fetch(12'd6));
        drain();
        // extrapolating weight, widest radius, extreme centers
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
        send_item(vertex(12'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
        send_item(vertex(12'd4, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000));
        send_item(vertex(12'd5, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(triangle(12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd8));
        send_item(fetch(12'd8));
        drain();
        // zero radius, no blend
        set_config(32'd123456, 32'hFFF0_0000, 32'd7, 32'd0, 32'd0);
        send_item(vertex(12'd6, 32'd1, 32'd2, 32'd3));
        send_item(vertex(12'd7, 32'hDEAD_BEEF, 32'h1234_5678, 32'h8000_0001));
        drain();
    endtask

    task automatic test_random(int unsigned phases, int unsigned per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            calm = (ph == 1);
            if (ph == 0)
                set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd65536);
            else
                set_config($urandom, $urandom, $urandom, $urandom_range(32'h0080_0000),
                           $urandom_range(3) == 0 ? $urandom_range(32'h1FFFF)
                                                  : $urandom_range(65536));
            repeat (per_phase) send_item(rand_item());
            drain();
        end
        calm = 0;
    endtask

    // Stop taking results for a long stretch while beats keep coming.
    task automatic test_backpressure();
        set_config(32'd0, 32'd0, 32'd0, 32'd65536, 32'd32768);
        @(posedge clk);
        hold_cycles = 3000;
        repeat (12) send_item(vertex(12'($urandom_range(15)), $urandom, $urandom, $urandom));
        repeat (4) send_item(fetch(12'($urandom_range(31))));
        drain();
    endtask

    //------------------------------------------------------------------
    // Receiver, monitor, watchdog
    //------------------------------------------------------------------
    always @(negedge clk) begin
        if (hold_cycles != 0) begin
            m_axis_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end
        else if (sink_stall != 0) begin
            m_axis_tready <= 0;
            sink_stall <= sink_stall - 1;
        end
        else begin
            m_axis_tready <= 1;
            if (!calm && $urandom_range(4) == 0) sink_stall <= idle_len();
        end
    end

    always @(posedge clk) begin
        beat_t want;
        logic [11:0] got_slot;
        logic [31:0] got_x, got_y, got_z;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            {got_z, got_y, got_x, got_slot} = m_axis_tdata[107:0];
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result beat: kind %0d slot %0d", m_axis_tuser,
                             got_slot);
            end
            else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (m_axis_tuser[0] !== want.rkind || got_slot !== want.slot ||
                    got_x !== want.x || got_y !== want.y || got_z !== want.z) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: exp kind %0d slot %0d (%h %h %h) got kind %0d slot %0d (%h %h %h)",
                                 want.rkind, want.slot, want.x, want.y, want.z,
                                 m_axis_tuser, got_slot, got_x, got_y, got_z);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
        radius = 64'(RADIUS_RESET);
        weight = 0;
        foreach (nrm_sum[s, i]) nrm_sum[s][i] = 0;
        foreach (vtx_store[s, i]) vtx_store[s][i] = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        test_directed();
        test_random(4, 125);
        test_backpressure();

        $display("beats in: %0d vertex, %0d triangle, %0d fetch, %0d idle-kind",
                 n_vertex, n_triangle, n_fetch, n_idle);
        $display("result beats checked: %0d, mismatches: %0d", beats_checked, mismatches);
        if (mismatches == 0 && expected_beats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sphere_morph_vertex_normals.f @@
design/sphm_pkg.sv
design/sphere_morph_vertex_normals.sv
verif/testbench.sv
